// ----- rtl/dibc_pkg.sv -----
// Shared types, constants and helper functions for the dual-index barcode classifier.
// No dependencies; imported by every module of the block.
package dibc_pkg;

    // Default sizing
    localparam int MAX_SAMPLES_DEF   = 64;
    localparam int BARCODE_CHARS_DEF = 8;

    // Fixed field widths
    localparam int CODE_BITS  = 64;
    localparam int TRIM_W     = 8;
    localparam int ROUTE_W    = 7;
    localparam int LEN_W      = 4;
    localparam int DIST_W     = 4;
    localparam int IDX_W      = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;
    localparam int IN_DATA_W  = 280;
    localparam int OUT_DATA_W = 32;

    // Operation codes (carried on tuser)
    localparam logic OP_LOAD     = 1'b0;
    localparam logic OP_CLASSIFY = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MISMATCH_LIMIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_LEN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_LEN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIM_DISABLE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT   = 3'd4;

    typedef struct packed {
        logic [LEN_W-1:0]   mismatch_limit;
        logic [LEN_W-1:0]   first_len;
        logic [LEN_W-1:0]   second_len;
        logic               trim_disable;
        logic [ROUTE_W-1:0] sample_count;
    } dibc_cfg_t;

    // Controller to datapath
    typedef struct packed {
        logic write_entry;
        logic start;
        logic rd_issue;
        logic load_out;
    } dibc_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_ok;
        logic last_issue;
        logic matched;
        logic out_free;
    } dibc_status_t;

    // Count differing bytes over the first len characters
    function automatic logic [DIST_W-1:0] hamming(
        input logic [CODE_BITS-1:0] a,
        input logic [CODE_BITS-1:0] b,
        input logic [LEN_W-1:0]     len
    );
        logic [DIST_W-1:0] d;
        d = '0;
        for (int k = 0; k < 8; k++) begin
            if ((LEN_W'(k) < len) && (a[8*k +: 8] != b[8*k +: 8]))
                d = d + DIST_W'(1);
        end
        return d;
    endfunction

    // Mask covering the first len characters
    function automatic logic [CODE_BITS-1:0] byte_mask(input logic [LEN_W-1:0] len);
        logic [CODE_BITS-1:0] m;
        m = '0;
        for (int k = 0; k < 8; k++) begin
            if (LEN_W'(k) < len)
                m[8*k +: 8] = 8'hFF;
        end
        return m;
    endfunction

endpackage

// ----- rtl/dibc_ctrl.sv -----
// Sequencing state machine for the barcode classifier: load, scan, drain, result.
// Depends on dibc_pkg.
module dibc_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_op,
    output logic                  in_ready,
    input  dibc_pkg::dibc_status_t status,
    output dibc_pkg::dibc_cmd_t    cmd
);
    import dibc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   in_fire;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;

    // Next state and commands
    always_comb
    begin
        state_next      = state_reg;
        cmd.write_entry = in_fire && (in_op == OP_LOAD);
        cmd.start       = in_fire && (in_op == OP_CLASSIFY);
        cmd.rd_issue    = 1'b0;
        cmd.load_out    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.start)
                    state_next = status.scan_ok ? ST_SCAN : ST_DONE;
            end
            ST_SCAN:
            begin
                // stop early once a route is known
                if (status.matched)
                    state_next = ST_DONE;
                else
                begin
                    cmd.rd_issue = 1'b1;
                    if (status.last_issue)
                        state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ----- rtl/dibc_datapath.sv -----
// Sample table memories, per-entry barcode matching and the result register.
// Depends on dibc_pkg; driven by dibc_ctrl commands.
module dibc_datapath
#(
    parameter int MAX_SAMPLES   = dibc_pkg::MAX_SAMPLES_DEF,
    parameter int BARCODE_CHARS = dibc_pkg::BARCODE_CHARS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  dibc_pkg::dibc_cfg_t                cfg,
    input  dibc_pkg::dibc_cmd_t                cmd,
    output dibc_pkg::dibc_status_t             status,
    input  logic [dibc_pkg::IDX_W-1:0]         entry_index,
    input  logic [dibc_pkg::CODE_BITS-1:0]     entry_first_code,
    input  logic [dibc_pkg::CODE_BITS-1:0]     entry_second_code,
    input  logic [dibc_pkg::TRIM_W-1:0]        entry_first_trim,
    input  logic [dibc_pkg::TRIM_W-1:0]        entry_second_trim,
    input  logic [dibc_pkg::CODE_BITS-1:0]     read_first_prefix,
    input  logic [dibc_pkg::CODE_BITS-1:0]     read_second_prefix,
    input  logic                              read_first_long_enough,
    input  logic                              read_second_long_enough,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic [dibc_pkg::ROUTE_W-1:0]       sample_route,
    output logic [dibc_pkg::TRIM_W-1:0]        trim_first,
    output logic [dibc_pkg::TRIM_W-1:0]        trim_second,
    output logic                              undetermined,
    output logic                              perfect_match
);
    import dibc_pkg::*;

    localparam int ADDR_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int BC_W   = 8 * BARCODE_CHARS;

    // Sample table
    logic [BC_W-1:0]     first_mem  [MAX_SAMPLES];
    logic [BC_W-1:0]     second_mem [MAX_SAMPLES];
    logic [2*TRIM_W-1:0] trim_mem   [MAX_SAMPLES];

    logic [BC_W-1:0]     rd_first_reg, rd_second_reg;
    logic [2*TRIM_W-1:0] rd_trim_reg;

    // Scan bookkeeping
    logic [ROUTE_W-1:0] cnt_reg, cnt_next;
    logic [ROUTE_W-1:0] eval_idx_reg;
    logic               eval_valid_reg;
    logic [BC_W-1:0]    read_first_reg, read_second_reg;

    // Match state
    logic               have0_reg, have0_next;
    logic               matched_reg, matched_next;
    logic [BC_W-1:0]    key_reg, key_next;
    logic [TRIM_W-1:0]  trim0_reg, trim0_next;
    logic [TRIM_W-1:0]  trim1_reg, trim1_next;
    logic [ROUTE_W-1:0] route_reg, route_next;
    logic               d0zero_reg, d0zero_next;
    logic               d1zero_reg, d1zero_next;

    // Result register
    logic               out_valid_reg;
    logic [ROUTE_W-1:0] out_route_reg;
    logic [TRIM_W-1:0]  out_trim0_reg, out_trim1_reg;
    logic               out_undet_reg, out_perfect_reg;

    logic [ROUTE_W-1:0]   n_eff;
    logic [LEN_W-1:0]     len0, len1;
    logic [BC_W-1:0]      mask0;
    logic [DIST_W-1:0]    d0, d1;
    logic                 pass0, pass1, key_eq, cand;
    logic                 load_in_range;

    // Effective count and barcode lengths
    assign n_eff = (32'(cfg.sample_count) > MAX_SAMPLES) ? ROUTE_W'(MAX_SAMPLES)
                                                         : cfg.sample_count;
    assign len0  = (32'(cfg.first_len) > BARCODE_CHARS) ? LEN_W'(BARCODE_CHARS)
                                                        : cfg.first_len;
    assign len1  = (32'(cfg.second_len) > BARCODE_CHARS) ? LEN_W'(BARCODE_CHARS)
                                                         : cfg.second_len;
    assign mask0 = BC_W'(byte_mask(len0));

    assign load_in_range = (32'(entry_index) < MAX_SAMPLES);

    // Table write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.write_entry && load_in_range)
        begin
            first_mem[ADDR_W'(entry_index)]  <= BC_W'(entry_first_code);
            second_mem[ADDR_W'(entry_index)] <= BC_W'(entry_second_code);
            trim_mem[ADDR_W'(entry_index)]   <= {entry_second_trim, entry_first_trim};
        end
        if (cmd.rd_issue)
        begin
            rd_first_reg  <= first_mem[ADDR_W'(cnt_reg)];
            rd_second_reg <= second_mem[ADDR_W'(cnt_reg)];
            rd_trim_reg   <= trim_mem[ADDR_W'(cnt_reg)];
        end
    end

    // Read prefixes held for the whole scan
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            read_first_reg  <= BC_W'(read_first_prefix);
            read_second_reg <= BC_W'(read_second_prefix);
        end
        if (cmd.rd_issue)
            eval_idx_reg <= cnt_reg;
    end

    // Per-entry distance checks
    assign d0     = hamming(CODE_BITS'(rd_first_reg), CODE_BITS'(read_first_reg), len0);
    assign d1     = hamming(CODE_BITS'(rd_second_reg), CODE_BITS'(read_second_reg), len1);
    assign pass0  = (d0 <= cfg.mismatch_limit);
    assign pass1  = (d1 <= cfg.mismatch_limit);
    assign key_eq = ((rd_first_reg & mask0) == key_reg);
    assign cand   = have0_reg ? key_eq : pass0;

    // Match state update
    always_comb
    begin
        cnt_next     = cnt_reg;
        have0_next   = have0_reg;
        matched_next = matched_reg;
        key_next     = key_reg;
        trim0_next   = trim0_reg;
        trim1_next   = trim1_reg;
        route_next   = route_reg;
        d0zero_next  = d0zero_reg;
        d1zero_next  = d1zero_reg;
        if (cmd.start)
        begin
            cnt_next     = '0;
            have0_next   = 1'b0;
            matched_next = 1'b0;
        end
        else
        begin
            if (cmd.rd_issue)
                cnt_next = cnt_reg + ROUTE_W'(1);
            if (eval_valid_reg && !matched_reg)
            begin
                // first barcode fixed by the first entry within the limit
                if (!have0_reg && pass0)
                begin
                    have0_next  = 1'b1;
                    key_next    = rd_first_reg & mask0;
                    trim0_next  = rd_trim_reg[TRIM_W-1:0];
                    d0zero_next = (d0 == '0);
                end
                if (cand && pass1)
                begin
                    matched_next = 1'b1;
                    route_next   = eval_idx_reg;
                    trim1_next   = rd_trim_reg[2*TRIM_W-1:TRIM_W];
                    d1zero_next  = (d1 == '0);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            eval_valid_reg <= 1'b0;
            have0_reg      <= 1'b0;
            matched_reg    <= 1'b0;
        end
        else
        begin
            cnt_reg        <= cnt_next;
            eval_valid_reg <= cmd.rd_issue;
            have0_reg      <= have0_next;
            matched_reg    <= matched_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        trim0_reg  <= trim0_next;
        trim1_reg  <= trim1_next;
        route_reg  <= route_next;
        d0zero_reg <= d0zero_next;
        d1zero_reg <= d1zero_next;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_route_reg   <= matched_reg ? route_reg : n_eff;
            out_trim0_reg   <= (matched_reg && !cfg.trim_disable) ? trim0_reg : '0;
            out_trim1_reg   <= (matched_reg && !cfg.trim_disable) ? trim1_reg : '0;
            out_undet_reg   <= !matched_reg;
            out_perfect_reg <= matched_reg && d0zero_reg && d1zero_reg;
        end
    end

    // Status back to the controller
    assign status.scan_ok    = read_first_long_enough && read_second_long_enough
                               && (n_eff != '0);
    assign status.last_issue = (cnt_reg == n_eff - ROUTE_W'(1));
    assign status.matched    = matched_reg;
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid     = out_valid_reg;
    assign sample_route  = out_route_reg;
    assign trim_first    = out_trim0_reg;
    assign trim_second   = out_trim1_reg;
    assign undetermined  = out_undet_reg;
    assign perfect_match = out_perfect_reg;

endmodule

// ----- rtl/dual_index_barcode_classifier_core.sv -----
// Top level of the dual-index barcode classifier: stream ports, config registers.
// Depends on dibc_pkg, dibc_ctrl and dibc_datapath.
//
//  Channel  Direction  Handshake                 Payload
//  s_axis   in         s_axis_tvalid/tready      tdata: entry or read fields, tuser: operation
//  m_axis   out        m_axis_tvalid/tready      tdata: route, trims, flags
//  cfg      in         cfg_valid/cfg_ready       cfg_index, cfg_data
//
// A load gives no result. A classify scans the table one entry per cycle through the
// memory read port, stopping early when a route is found and skipping the scan when
// a read is too short or the count is zero.
// A finished result waits in the output register; the next item is taken meanwhile.
// rst_n clears control state and sets the registers to their defaults; tables
// are not cleared. Config writes are always taken.
module dual_index_barcode_classifier_core
#(
    parameter int MAX_SAMPLES   = dibc_pkg::MAX_SAMPLES_DEF,
    parameter int BARCODE_CHARS = dibc_pkg::BARCODE_CHARS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    // tdata from bit 0 up: entry_index, entry_first_code, entry_second_code,
    // entry_first_trim, entry_second_trim, read_first_prefix, read_second_prefix,
    // read_first_long_enough, read_second_long_enough
    input  logic [dibc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // tuser: operation
    input  logic                              s_axis_tuser,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata from bit 0 up: sample_route, trim_first, trim_second, undetermined,
    // perfect_match, zero fill
    output logic [dibc_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dibc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dibc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import dibc_pkg::*;

    dibc_cfg_t    cfg_reg;
    dibc_cmd_t    cmd;
    dibc_status_t status;

    logic [ROUTE_W-1:0] sample_route;
    logic [TRIM_W-1:0]  trim_first, trim_second;
    logic               undetermined, perfect_match;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mismatch_limit <= LEN_W'(1);
            cfg_reg.first_len      <= LEN_W'(8);
            cfg_reg.second_len     <= LEN_W'(8);
            cfg_reg.trim_disable   <= 1'b0;
            cfg_reg.sample_count   <= ROUTE_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MISMATCH_LIMIT: cfg_reg.mismatch_limit <= cfg_data[LEN_W-1:0];
                CFG_FIRST_LEN:      cfg_reg.first_len      <= cfg_data[LEN_W-1:0];
                CFG_SECOND_LEN:     cfg_reg.second_len     <= cfg_data[LEN_W-1:0];
                CFG_TRIM_DISABLE:   cfg_reg.trim_disable   <= cfg_data[0];
                CFG_SAMPLE_COUNT:   cfg_reg.sample_count   <= cfg_data[ROUTE_W-1:0];
                default:            ;
            endcase
        end
    end

    // Sequencer
    dibc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_op    (s_axis_tuser),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Table, matching and result register
    dibc_datapath
    #(
        .MAX_SAMPLES   (MAX_SAMPLES),
        .BARCODE_CHARS (BARCODE_CHARS)
    )
    u_datapath
    (
        .clk                     (clk),
        .rst_n                   (rst_n),
        .cfg                     (cfg_reg),
        .cmd                     (cmd),
        .status                  (status),
        .entry_index             (s_axis_tdata[5:0]),
        .entry_first_code        (s_axis_tdata[69:6]),
        .entry_second_code       (s_axis_tdata[133:70]),
        .entry_first_trim        (s_axis_tdata[141:134]),
        .entry_second_trim       (s_axis_tdata[149:142]),
        .read_first_prefix       (s_axis_tdata[213:150]),
        .read_second_prefix      (s_axis_tdata[277:214]),
        .read_first_long_enough  (s_axis_tdata[278]),
        .read_second_long_enough (s_axis_tdata[279]),
        .out_ready               (m_axis_tready),
        .out_valid               (m_axis_tvalid),
        .sample_route            (sample_route),
        .trim_first              (trim_first),
        .trim_second             (trim_second),
        .undetermined            (undetermined),
        .perfect_match           (perfect_match)
    );

    assign m_axis_tdata = {7'b0, perfect_match, undetermined, trim_second, trim_first,
                           sample_route};

endmodule

// ----- test/tb_dual_index_barcode_classifier_core.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for dual_index_barcode_classifier_core: loads sample tables,
// classifies read pairs and checks every result against a behavioral scoreboard.
// Depends on dibc_pkg and the classifier RTL.
module tb_dual_index_barcode_classifier_core;
    import dibc_pkg::*;

    localparam int TABLE_DEPTH      = 64;
    localparam int CODE_BYTES       = 8;
    localparam int POOL_SIZE        = 8;
    localparam int SETTLE_CYCLES    = 100;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int RANDOM_PHASES    = 10;
    localparam int PHASE_ITEMS      = 180;
    localparam int CYCLE_LIMIT      = 1000000;
    localparam int REPORT_LIMIT     = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 3'd7;

    // Input request, first member in the top bits so slot lands at bit 0
    typedef struct packed {
        logic        second_ok;
        logic        first_ok;
        logic [63:0] second_prefix;
        logic [63:0] first_prefix;
        logic [7:0]  second_trim;
        logic [7:0]  first_trim;
        logic [63:0] second_code;
        logic [63:0] first_code;
        logic [5:0]  slot;
    } barcode_request_t;

    // Classification result as carried on m_axis_tdata
    typedef struct packed {
        logic [6:0] fill;
        logic       perfect;
        logic       undetermined;
        logic [7:0] second_trim;
        logic [7:0] first_trim;
        logic [6:0] route;
    } barcode_result_t;

    // Sample table copy, register copy and queue of predicted classifications
    class barcode_scoreboard;
        logic [63:0]     first_codes [TABLE_DEPTH];
        logic [63:0]     second_codes [TABLE_DEPTH];
        logic [7:0]      first_trims [TABLE_DEPTH];
        logic [7:0]      second_trims [TABLE_DEPTH];
        logic [3:0]      mismatch_limit;
        logic [3:0]      first_len;
        logic [3:0]      second_len;
        logic            trim_off;
        logic [6:0]      sample_count;
        barcode_result_t pending_calls [$];
        int              mismatches;

        function new();
            mismatch_limit = 4'd1;
            first_len      = 4'd8;
            second_len     = 4'd8;
            trim_off       = 1'b0;
            sample_count   = 7'd1;
            mismatches     = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_MISMATCH_LIMIT: mismatch_limit = data[3:0];
                CFG_FIRST_LEN:      first_len      = data[3:0];
                CFG_SECOND_LEN:     second_len     = data[3:0];
                CFG_TRIM_DISABLE:   trim_off       = data[0];
                CFG_SAMPLE_COUNT:   sample_count   = data[6:0];
                default: ;
            endcase
        endfunction

        // Differing characters over the first nbytes bytes
        function int unsigned byte_diffs(logic [63:0] a, logic [63:0] b, int unsigned nbytes);
            int unsigned d;
            d = 0;
            for (int k = 0; k < nbytes; k++)
            begin
                if (a[8*k +: 8] != b[8*k +: 8])
                    d++;
            end
            return d;
        endfunction

        // Two-stage scan: first barcode fixes the group, second barcode picks the route
        function barcode_result_t classify_read(barcode_request_t rq);
            barcode_result_t r;
            int unsigned     n, l0, l1, d0, d1, first_hit;
            logic            have_first, hit;
            logic [63:0]     m0, key;
            r          = '0;
            n          = (sample_count > TABLE_DEPTH) ? TABLE_DEPTH : sample_count;
            l0         = (first_len > CODE_BYTES) ? CODE_BYTES : first_len;
            l1         = (second_len > CODE_BYTES) ? CODE_BYTES : second_len;
            m0         = (l0 >= CODE_BYTES) ? {64{1'b1}} : ((64'd1 << (8 * l0)) - 64'd1);
            have_first = 1'b0;
            hit        = 1'b0;
            d0         = 0;
            d1         = 0;
            first_hit  = 0;
            key        = '0;
            r.route    = n[6:0];
            if (rq.first_ok && rq.second_ok)
            begin
                for (int i = 0; i < n && !have_first; i++)
                begin
                    d0 = byte_diffs(first_codes[i], rq.first_prefix, l0);
                    if (d0 <= mismatch_limit)
                    begin
                        have_first = 1'b1;
                        first_hit  = i;
                    end
                end
                if (have_first)
                begin
                    key = first_codes[first_hit] & m0;
                    for (int j = first_hit; j < n && !hit; j++)
                    begin
                        if ((first_codes[j] & m0) == key)
                        begin
                            d1 = byte_diffs(second_codes[j], rq.second_prefix, l1);
                            if (d1 <= mismatch_limit)
                            begin
                                hit           = 1'b1;
                                r.route       = 7'(j);
                                r.first_trim  = first_trims[first_hit];
                                r.second_trim = second_trims[j];
                            end
                        end
                    end
                end
            end
            if (!hit || trim_off)
            begin
                r.first_trim  = '0;
                r.second_trim = '0;
            end
            r.undetermined = !hit;
            r.perfect      = hit && (d0 == 0) && (d1 == 0);
            return r;
        endfunction

        function void note_request(barcode_request_t rq, logic op);
            if (op == OP_LOAD)
            begin
                first_codes[rq.slot]  = rq.first_code;
                second_codes[rq.slot] = rq.second_code;
                first_trims[rq.slot]  = rq.first_trim;
                second_trims[rq.slot] = rq.second_trim;
            end
            else
                pending_calls.insert(pending_calls.size(), classify_read(rq));
        endfunction

        function void flag(string what);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("mismatch at %0t: %s", $realtime, what);
        endfunction

        function void check_result(barcode_result_t got);
            barcode_result_t want;
            if (pending_calls.size() == 0)
            begin
                flag($sformatf("unexpected result route %0d trims %0d/%0d undet %0b perfect %0b",
                    got.route, got.first_trim, got.second_trim, got.undetermined, got.perfect));
                return;
            end
            want = pending_calls.pop_front();
            if (got.route !== want.route || got.first_trim !== want.first_trim ||
                got.second_trim !== want.second_trim || got.undetermined !== want.undetermined ||
                got.perfect !== want.perfect || got.fill !== want.fill)
                flag($sformatf({"expected route %0d trims %0d/%0d undet %0b perfect %0b fill %h, ",
                    "got route %0d trims %0d/%0d undet %0b perfect %0b fill %h"},
                    want.route, want.first_trim, want.second_trim, want.undetermined,
                    want.perfect, want.fill, got.route, got.first_trim, got.second_trim,
                    got.undetermined, got.perfect, got.fill));
        endfunction
    endclass

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tuser  = OP_LOAD;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;

    bit                    idle_on       = 1'b1;
    bit                    hold_request  = 1'b0;
    int unsigned           cycle_count   = 0;
    logic [63:0]           first_pool [POOL_SIZE];
    logic [63:0]           second_pool [POOL_SIZE];
    barcode_scoreboard     board;

    dual_index_barcode_classifier_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_dual_index_barcode_classifier_core: done, errors");
            $finish;
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(barcode_result_t'(m_axis_tdata));
    end

    // Receiver: random stall bursts, plus one long hold-off on request
    initial
    begin : receiver
        int stall;
        stall = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                m_axis_tready <= 1'b0;
                for (int c = 1; c < LONG_HOLD_CYCLES; c++)
                    @(negedge clk);
                hold_request = 1'b0;
            end
            else if (stall > 0)
            begin
                stall--;
                m_axis_tready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                stall = $urandom_range(1, 19) - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    function automatic logic [63:0] random_word();
        return {$urandom, $urandom};
    endfunction

    // Eight random nucleotide letters
    function automatic logic [63:0] random_bases();
        logic [63:0] w;
        w = '0;
        for (int k = 0; k < CODE_BYTES; k++)
        begin
            case ($urandom_range(0, 3))
                0: w[8*k +: 8] = "A";
                1: w[8*k +: 8] = "C";
                2: w[8*k +: 8] = "G";
                default: w[8*k +: 8] = "T";
            endcase
        end
        return w;
    endfunction

    // Change count distinct character positions
    function automatic logic [63:0] mutate_bytes(logic [63:0] code, int unsigned count);
        int          order [CODE_BYTES];
        int          pick, swap;
        logic [63:0] w;
        w = code;
        for (int i = 0; i < CODE_BYTES; i++)
            order[i] = i;
        for (int i = CODE_BYTES - 1; i > 0; i--)
        begin
            pick        = $urandom_range(0, i);
            swap        = order[i];
            order[i]    = order[pick];
            order[pick] = swap;
        end
        for (int i = 0; i < count && i < CODE_BYTES; i++)
            w[8*order[i] +: 8] = code[8*order[i] +: 8] + 8'($urandom_range(1, 255));
        return w;
    endfunction

    // Mostly shared pool codes, so several entries fall into one first-barcode group
    function automatic logic [63:0] pick_code(bit second_side);
        logic [63:0] base;
        base = second_side ? second_pool[$urandom_range(0, POOL_SIZE - 1)]
                           : first_pool[$urandom_range(0, POOL_SIZE - 1)];
        case ($urandom_range(0, 7))
            0, 1, 2, 3: return base;
            4, 5:       return mutate_bytes(base, 1);
            6:          return random_bases();
            default:    return random_word();
        endcase
    endfunction

    function automatic barcode_request_t random_request();
        barcode_request_t rq;
        rq.slot          = 6'($urandom);
        rq.first_code    = random_word();
        rq.second_code   = random_word();
        rq.first_trim    = 8'($urandom);
        rq.second_trim   = 8'($urandom);
        rq.first_prefix  = random_word();
        rq.second_prefix = random_word();
        rq.first_ok      = 1'($urandom);
        rq.second_ok     = 1'($urandom);
        return rq;
    endfunction

    function automatic barcode_request_t make_load(int unsigned slot);
        barcode_request_t rq;
        rq             = random_request();
        rq.slot        = 6'(slot);
        rq.first_code  = pick_code(1'b0);
        rq.second_code = pick_code(1'b1);
        return rq;
    endfunction

    // Mostly reads derived from a table entry with a few changed characters
    function automatic barcode_request_t make_classify();
        barcode_request_t rq;
        int unsigned      n, j, spread;
        rq     = random_request();
        n      = (board.sample_count > TABLE_DEPTH) ? TABLE_DEPTH : board.sample_count;
        j      = (n == 0) ? $urandom_range(0, TABLE_DEPTH - 1) : $urandom_range(0, n - 1);
        spread = (board.mismatch_limit >= CODE_BYTES) ? CODE_BYTES : board.mismatch_limit + 1;
        if ($urandom_range(0, 9) < 7)
        begin
            rq.first_prefix  = mutate_bytes(board.first_codes[j], $urandom_range(0, spread));
            rq.second_prefix = mutate_bytes(board.second_codes[j], $urandom_range(0, spread));
        end
        else if ($urandom_range(0, 1) == 0)
        begin
            rq.first_prefix  = mutate_bytes(pick_code(1'b0), $urandom_range(0, spread));
            rq.second_prefix = mutate_bytes(pick_code(1'b1), $urandom_range(0, spread));
        end
        rq.first_ok  = ($urandom_range(0, 39) != 0);
        rq.second_ok = ($urandom_range(0, 39) != 0);
        return rq;
    endfunction

    // Offer one request, with an optional idle burst in front
    task automatic send_request(barcode_request_t rq, logic op);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 19);
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rq;
        s_axis_tuser  <= op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        board.note_request(rq, op);
    endtask

    task automatic send_load(int unsigned slot, logic [63:0] c1, logic [63:0] c2,
                             logic [7:0] t1, logic [7:0] t2);
        barcode_request_t rq;
        rq             = random_request();
        rq.slot        = 6'(slot);
        rq.first_code  = c1;
        rq.second_code = c2;
        rq.first_trim  = t1;
        rq.second_trim = t2;
        send_request(rq, OP_LOAD);
    endtask

    task automatic send_classify(logic [63:0] p1, logic [63:0] p2, logic ok1, logic ok2);
        barcode_request_t rq;
        rq               = random_request();
        rq.first_prefix  = p1;
        rq.second_prefix = p2;
        rq.first_ok      = ok1;
        rq.second_ok     = ok2;
        send_request(rq, OP_CLASSIFY);
    endtask

    // Leaves cfg_valid high; apply_settings lowers it after the last write
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.set_register(idx, data);
    endtask

    // Unused upper data bits carry junk that the block must drop
    task automatic apply_settings(int unsigned limit, int unsigned l0, int unsigned l1,
                                  int unsigned toff, int unsigned count);
        write_register(CFG_MISMATCH_LIMIT, {3'($urandom), 4'(limit)});
        write_register(CFG_FIRST_LEN, {3'($urandom), 4'(l0)});
        write_register(CFG_SECOND_LEN, {3'($urandom), 4'(l1)});
        write_register(CFG_TRIM_DISABLE, {6'($urandom), 1'(toff)});
        write_register(CFG_SAMPLE_COUNT, 7'(count));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Drop valid, wait for every predicted result, then let a trailing load finish
    task automatic settle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (board.pending_calls.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        logic [63:0] code_a, code_b, code_c, code_d, code_e;
        board = new();
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            first_pool[i]  = random_bases();
            second_pool[i] = random_bases();
        end
        code_a = random_bases();
        code_b = random_bases();
        code_c = random_bases();
        code_d = random_bases();
        code_e = mutate_bytes(code_d, 3);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: reset settings, one sample entry
        send_load(0, code_a, code_b, 8'hFF, 8'h00);
        send_classify(code_a, code_b, 1'b1, 1'b1);
        send_classify(mutate_bytes(code_a, 1), code_b, 1'b1, 1'b1);
        send_classify(code_a, mutate_bytes(code_b, 2), 1'b1, 1'b1);
        send_classify(code_a, code_b, 1'b0, 1'b1);
        send_classify(code_a, code_b, 1'b1, 1'b0);
        send_classify({64{1'b1}}, 64'd0, 1'b1, 1'b1);

        // Directed: group of two entries sharing a first barcode
        send_load(1, code_c, code_d, 8'h00, 8'hFF);
        send_load(2, code_c, code_e, 8'd17, 8'd34);
        send_load(3, mutate_bytes(code_c, 1), code_e, 8'd51, 8'd68);
        settle();
        write_register(CFG_UNUSED_INDEX, 7'h7F);
        apply_settings(1, 8, 8, 0, 4);
        send_classify(code_c, code_e, 1'b1, 1'b1);
        send_classify(mutate_bytes(code_c, 1), code_d, 1'b1, 1'b1);
        settle();
        apply_settings(1, 7, 8, 0, 4);
        send_classify(mutate_bytes(code_c, 1), code_e, 1'b1, 1'b1);

        // Directed: zero lengths with trimming off, then an empty sample count
        settle();
        apply_settings(0, 0, 0, 1, 4);
        send_classify(random_word(), random_word(), 1'b1, 1'b1);
        settle();
        apply_settings(1, 8, 8, 0, 0);
        send_classify(code_a, code_b, 1'b1, 1'b1);

        // Fill the whole table before any wider scan
        for (int s = 0; s < TABLE_DEPTH; s++)
            send_request(make_load(s), OP_LOAD);

        // Directed: limit above length, saturating length and count
        settle();
        apply_settings(15, 12, 12, 0, 100);
        send_request(make_classify(), OP_CLASSIFY);
        send_classify({64{1'b1}}, {64{1'b1}}, 1'b1, 1'b1);

        // Random phases, the first few at extreme settings, the last without idling
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            settle();
            case (phase)
                0: apply_settings(0, 8, 8, 0, 64);
                1: apply_settings(8, 1, 1, 0, 32);
                2: apply_settings(1, 0, 15, 1, 127);
                3: apply_settings(15, 8, 8, 0, 1);
                default:
                    apply_settings(
                        ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(0, 15),
                        ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8) : $urandom_range(0, 15),
                        ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8) : $urandom_range(0, 15),
                        $urandom_range(0, 1),
                        ($urandom_range(0, 9) < 8) ? $urandom_range(1, 64) : $urandom_range(0, 127));
            endcase
            first_pool[$urandom_range(0, POOL_SIZE - 1)]  = random_bases();
            second_pool[$urandom_range(0, POOL_SIZE - 1)] = random_bases();
            idle_on = (phase != RANDOM_PHASES - 1);
            if (phase == 1)
                hold_request = 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if ($urandom_range(0, 99) < 15)
                    send_request(make_load($urandom_range(0, TABLE_DEPTH - 1)), OP_LOAD);
                else
                    send_request(make_classify(), OP_CLASSIFY);
            end
        end

        settle();
        if (board.mismatches == 0 && board.pending_calls.size() == 0)
            $display("tb_dual_index_barcode_classifier_core: done, clean");
        else
            $display("tb_dual_index_barcode_classifier_core: done, errors");
        $finish;
    end

endmodule
